// File: rtl/h2r_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h2r_pkg
// Shared constants and types for the HSL to RGB color converter: fixed-point
// widths, hue constants, the division-by-sixty reciprocal and sextant codes.
// ----------------------------------------------------------------------------
package h2r_pkg;

  // Fraction width; full scale (2^FW - 1) stands for 1.0.
  localparam int FW = 12;
  localparam int FS = (1 << FW) - 1;

  // Width of the input and output fields.
  localparam int IOW = 12;
  localparam int OUT_MAX = (1 << IOW) - 1;

  // Common width that holds both a field value and a fraction.
  localparam int OW = (FW > IOW) ? FW : IOW;

  // Hue constants in whole degrees.
  localparam int HUE_WRAP = 360;
  localparam int HUE_SPAN = 60;

  // Offset-times-span product and its reciprocal for the divide by sixty.
  localparam int OFFW = 6;
  localparam int YW = FW + OFFW;
  localparam int KW = FW + 1;
  localparam int RECIP_K = (1 << YW) / HUE_SPAN;

  // Number of register stages from an accepted word to its result.
  localparam int LATENCY = 9;

  // Sextant of the hue circle, named by the colors at its two ends.
  typedef enum logic [2:0] {
    SEXT_R_TO_Y = 3'd0,
    SEXT_Y_TO_G = 3'd1,
    SEXT_G_TO_C = 3'd2,
    SEXT_C_TO_B = 3'd3,
    SEXT_B_TO_M = 3'd4,
    SEXT_M_TO_R = 3'd5
  } sextant_t;

endpackage

// File: rtl/hsl_to_rgb_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_to_rgb_unit
// Converts a color from hue, saturation and lightness to red, green and blue
// fractions in a nine-stage pipeline with no state between words.
// ----------------------------------------------------------------------------
// Usage:
//   Drive hue_degrees, saturation and lightness and raise start for one
//   cycle per word. A word is taken at each rising edge where start is high
//   and busy is low. busy is always low, so a word may enter every cycle.
//   The result word appears on red, green and blue for exactly one cycle,
//   marked by done, once its input word has passed through all nine register
//   stages. Results leave in input order at one word per clock. The stages
//   hold the clamp and hue decode, the saturation-lightness product, the
//   divide by full scale, the peak, the floor, the offset product, the
//   divide by sixty with its correction, and the output selection.
//   The receiver has no way to hold results off; it must take each result
//   in the cycle where done is high.
//   Reset (rst, synchronous, active high) clears every stage valid bit, so
//   no stale result is given after reset; words in flight are dropped.
// ----------------------------------------------------------------------------
module hsl_to_rgb_unit
  import h2r_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  logic [8:0]           hue_degrees,
  input  logic [IOW-1:0]       saturation,
  input  logic [IOW-1:0]       lightness,
  output logic                 done,
  output logic [IOW-1:0]       red,
  output logic [IOW-1:0]       green,
  output logic [IOW-1:0]       blue
);

  // Valid bit per stage.
  logic [LATENCY-1:0] vld;

  // Stage 1: clamped fractions and decoded hue.
  logic [FW-1:0]    st1_s, st1_l;
  sextant_t         st1_sext;
  logic [OFFW-1:0]  st1_off;
  // Stage 2: product of lightness and saturation.
  logic [2*FW-1:0]  st2_p;
  logic [FW-1:0]    st2_s, st2_l;
  sextant_t         st2_sext;
  logic [OFFW-1:0]  st2_off;
  // Stage 3: product divided by full scale.
  logic [FW-1:0]    st3_d, st3_s, st3_l;
  sextant_t         st3_sext;
  logic [OFFW-1:0]  st3_off;
  // Stage 4: peak.
  logic [FW-1:0]    st4_v, st4_l;
  sextant_t         st4_sext;
  logic [OFFW-1:0]  st4_off;
  // Stage 5: floor.
  logic [FW-1:0]    st5_v, st5_m;
  sextant_t         st5_sext;
  logic [OFFW-1:0]  st5_off;
  // Stage 6: span times offset.
  logic [YW-1:0]    st6_y;
  logic [FW-1:0]    st6_v, st6_m;
  sextant_t         st6_sext;
  // Stage 7: estimated quotient by sixty.
  logic [FW-1:0]    st7_q;
  logic [YW-1:0]    st7_y;
  logic [FW-1:0]    st7_v, st7_m;
  sextant_t         st7_sext;
  // Stage 8: corrected in-sextant offset.
  logic [FW-1:0]    st8_vsf, st8_v, st8_m;
  sextant_t         st8_sext;

  logic accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign done   = vld[LATENCY-1];

  // Valid bits shift along with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-2:0], accept};
    end
  end

  // Stage 1 logic: clamp fractions, wrap hue and split it into sextant.
  logic [OW-1:0]   s_ext, l_ext;
  logic [FW-1:0]   s_clamp, l_clamp;
  logic [8:0]      hue_w;
  logic [8:0]      hue_base;
  logic [8:0]      hue_rem;
  sextant_t        sext_next;

  always_comb begin
    s_ext   = OW'(saturation);
    l_ext   = OW'(lightness);
    s_clamp = (s_ext > OW'(FS)) ? FW'(FS) : s_ext[FW-1:0];
    l_clamp = (l_ext > OW'(FS)) ? FW'(FS) : l_ext[FW-1:0];
    hue_w   = (hue_degrees >= 9'(HUE_WRAP)) ? hue_degrees - 9'(HUE_WRAP)
                                           : hue_degrees;
    if (hue_w >= 9'(5 * HUE_SPAN)) begin
      sext_next = SEXT_M_TO_R;
      hue_base  = 9'(5 * HUE_SPAN);
    end else if (hue_w >= 9'(4 * HUE_SPAN)) begin
      sext_next = SEXT_B_TO_M;
      hue_base  = 9'(4 * HUE_SPAN);
    end else if (hue_w >= 9'(3 * HUE_SPAN)) begin
      sext_next = SEXT_C_TO_B;
      hue_base  = 9'(3 * HUE_SPAN);
    end else if (hue_w >= 9'(2 * HUE_SPAN)) begin
      sext_next = SEXT_G_TO_C;
      hue_base  = 9'(2 * HUE_SPAN);
    end else if (hue_w >= 9'(HUE_SPAN)) begin
      sext_next = SEXT_Y_TO_G;
      hue_base  = 9'(HUE_SPAN);
    end else begin
      sext_next = SEXT_R_TO_Y;
      hue_base  = 9'd0;
    end
    hue_rem = hue_w - hue_base;
  end

  // Stage 3 logic: p / FS is hi + lo over FS, with one carry at most.
  logic [FW-1:0] p_hi, p_lo;
  logic [FW:0]   p_sum;
  logic [FW-1:0] d_next;

  always_comb begin
    p_hi   = st2_p[2*FW-1:FW];
    p_lo   = st2_p[FW-1:0];
    p_sum  = {1'b0, p_hi} + {1'b0, p_lo};
    d_next = (p_sum >= (FW+1)'(FS)) ? p_hi + FW'(1) : p_hi;
  end

  // Stage 4 logic: peak from lightness, saturation and their scaled product.
  logic [FW:0] v_wide;

  always_comb begin
    if ({st3_l, 1'b0} <= (FW+1)'(FS)) begin
      v_wide = {1'b0, st3_l} + {1'b0, st3_d};
    end else begin
      v_wide = {1'b0, st3_l} + {1'b0, st3_s} - {1'b0, st3_d};
    end
  end

  // Stage 5 logic: floor 2L - v, clamped to the range zero to peak.
  logic signed [FW+1:0] m_wide;
  logic [FW-1:0]        m_next;

  always_comb begin
    m_wide = $signed({1'b0, st4_l, 1'b0}) - $signed({2'b00, st4_v});
    if (m_wide < 0) begin
      m_next = '0;
    end else if (m_wide > $signed({2'b00, st4_v})) begin
      m_next = st4_v;
    end else begin
      m_next = m_wide[FW-1:0];
    end
  end

  // Stage 7 logic: quotient by sixty from the reciprocal, low by one at most.
  logic [KW-1:0]    recip;
  logic [YW+KW-1:0] yk;

  always_comb begin
    recip = KW'(RECIP_K);
    yk    = (YW+KW)'(st6_y) * (YW+KW)'(recip);
  end

  // Stage 8 logic: correct the estimate by the remainder.
  logic [YW-1:0] rem;
  logic [FW-1:0] vsf_next;

  always_comb begin
    rem      = st7_y - YW'(st7_q) * YW'(HUE_SPAN);
    vsf_next = (rem >= YW'(HUE_SPAN)) ? st7_q + FW'(1) : st7_q;
  end

  // Stage 9 logic: rising and falling edges and the sextant selection.
  logic [FW-1:0] mid1, mid2;
  logic [FW-1:0] r_sel, g_sel, b_sel;

  function automatic logic [IOW-1:0] sat_field(input logic [FW-1:0] x);
    logic [OW-1:0] xe;
    xe = OW'(x);
    if (xe > OW'(OUT_MAX)) begin
      return IOW'(OUT_MAX);
    end
    return xe[IOW-1:0];
  endfunction

  always_comb begin
    mid1 = st8_m + st8_vsf;
    mid2 = st8_v - st8_vsf;
    case (st8_sext)
      SEXT_R_TO_Y: begin
        r_sel = st8_v;  g_sel = mid1;   b_sel = st8_m;
      end
      SEXT_Y_TO_G: begin
        r_sel = mid2;   g_sel = st8_v;  b_sel = st8_m;
      end
      SEXT_G_TO_C: begin
        r_sel = st8_m;  g_sel = st8_v;  b_sel = mid1;
      end
      SEXT_C_TO_B: begin
        r_sel = st8_m;  g_sel = mid2;   b_sel = st8_v;
      end
      SEXT_B_TO_M: begin
        r_sel = mid1;   g_sel = st8_m;  b_sel = st8_v;
      end
      default: begin
        r_sel = st8_v;  g_sel = st8_m;  b_sel = mid2;
      end
    endcase
  end

  // Pipeline data registers; they need no reset.
  always_ff @(posedge clk) begin
    st1_s    <= s_clamp;
    st1_l    <= l_clamp;
    st1_sext <= sext_next;
    st1_off  <= hue_rem[OFFW-1:0];

    st2_p    <= (2*FW)'(st1_l) * (2*FW)'(st1_s);
    st2_s    <= st1_s;
    st2_l    <= st1_l;
    st2_sext <= st1_sext;
    st2_off  <= st1_off;

    st3_d    <= d_next;
    st3_s    <= st2_s;
    st3_l    <= st2_l;
    st3_sext <= st2_sext;
    st3_off  <= st2_off;

    st4_v    <= v_wide[FW-1:0];
    st4_l    <= st3_l;
    st4_sext <= st3_sext;
    st4_off  <= st3_off;

    st5_v    <= st4_v;
    st5_m    <= m_next;
    st5_sext <= st4_sext;
    st5_off  <= st4_off;

    st6_y    <= YW'(st5_v - st5_m) * YW'(st5_off);
    st6_v    <= st5_v;
    st6_m    <= st5_m;
    st6_sext <= st5_sext;

    st7_q    <= yk[YW+FW-1:YW];
    st7_y    <= st6_y;
    st7_v    <= st6_v;
    st7_m    <= st6_m;
    st7_sext <= st6_sext;

    st8_vsf  <= vsf_next;
    st8_v    <= st7_v;
    st8_m    <= st7_m;
    st8_sext <= st7_sext;

    red      <= sat_field(r_sel);
    green    <= sat_field(g_sel);
    blue     <= sat_field(b_sel);
  end

  // Every accepted word gives exactly one result after the pipeline depth.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("accepted word gave no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result without an accepted word");

  // Zero lightness gives black.
  a_black: assert property (@(posedge clk) disable iff (rst)
    (accept && lightness == '0) |-> ##LATENCY
      (red == '0 && green == '0 && blue == '0))
    else $error("zero lightness did not give black");

  // Zero saturation gives a gray.
  a_gray: assert property (@(posedge clk) disable iff (rst)
    (accept && saturation == '0) |-> ##LATENCY (red == green && green == blue))
    else $error("zero saturation did not give gray");

endmodule
